// ===== hw/rtl/ksdr_pkg.sv =====
// shared types, widths and usage codes of the key scan debounce report block
`timescale 1ns / 1ps
package ksdr_pkg;

	// default sizes
	localparam int KEYS_DEF           = 64;
	localparam int KEY_SLOTS_DEF      = 6;
	localparam int STABLE_SAMPLES_DEF = 5;

	// fixed field widths
	localparam int IDX_W       = 6;
	localparam int USAGE_W     = 8;
	localparam int HIST_W      = 8;
	localparam int CNT_W       = 16;
	localparam int SHOWN_SLOTS = 6;

	// word opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// configuration register indexes
	localparam int   CFG_IDX_W      = 1;
	localparam logic CFG_RIGHT_SIDE = 1'b0;
	localparam logic CFG_NUMPAD     = 1'b1;

	// hid usage codes
	localparam logic [4:0]         MOD_PREFIX      = 5'h1C;
	localparam logic [USAGE_W-1:0] USAGE_GUI_LEFT  = 8'hE3;
	localparam logic [USAGE_W-1:0] USAGE_GUI_RIGHT = 8'hE7;
	localparam logic [USAGE_W-1:0] USAGE_SPACE     = 8'h2C;
	localparam logic [USAGE_W-1:0] USAGE_COMMA     = 8'h36;

	// one boot report as it leaves the block
	typedef struct packed {
		logic [USAGE_W-1:0]                  modifier_bits;
		logic [SHOWN_SLOTS-1:0][USAGE_W-1:0] slots;
		logic                                game_mode_on;
		logic [CNT_W-1:0]                    new_press_count;
	} report_t;

endpackage

// ===== hw/rtl/ksdr_if.sv =====
// valid/ready channel interfaces for key words and boot reports
`timescale 1ns / 1ps
interface key_in_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [ksdr_pkg::IDX_W-1:0]    key_index;
	logic                          pressed;
	logic                          scan_last;
	logic                          table_select;
	logic [ksdr_pkg::USAGE_W-1:0]  usage_code;

	modport source (output valid, opcode, key_index, pressed, scan_last, table_select,
		usage_code, input ready);
	modport sink (input valid, opcode, key_index, pressed, scan_last, table_select,
		usage_code, output ready);
endinterface

interface report_if;
	logic                          valid;
	logic                          ready;
	logic [ksdr_pkg::USAGE_W-1:0]  modifier_bits;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_zero;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_one;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_two;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_three;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_four;
	logic [ksdr_pkg::USAGE_W-1:0]  slot_five;
	logic                          game_mode_on;
	logic [ksdr_pkg::CNT_W-1:0]    new_press_count;

	modport source (output valid, modifier_bits, slot_zero, slot_one, slot_two, slot_three,
		slot_four, slot_five, game_mode_on, new_press_count, input ready);
	modport sink (input valid, modifier_bits, slot_zero, slot_one, slot_two, slot_three,
		slot_four, slot_five, game_mode_on, new_press_count, output ready);
endinterface

// ===== hw/rtl/key_scan_debounce_report_core.sv =====
// key scan debouncer and hid boot report builder, top level
//
// in_ch carries one word per clock while in_ch.ready is high: a key sample in
// scan order (opcode sample) or a keymap entry load (opcode load).
// cfg_we/cfg_index/cfg_data write the two side-presence registers; the user must
// do so only while the block is idle, the block itself does not enforce it.
// out_ch carries one boot report for every sample word flagged scan_last.
// Throughput is one word per cycle while in_ch.ready is high. Per-key history
// lives in a registered-read memory: a sample reads it on acceptance and writes
// it back in the next cycle, with a bypass register covering back-to-back
// samples of the same key. Reports pass the stage 1 registers and wait in a
// two-deep output queue; in_ch.ready drops only when the queue and the word in
// flight would overflow it, so a stalled receiver stops input after at most two
// pending reports and loses nothing. Reset clears history through per-key valid
// flops at once (no clearing pass), clears report state, game mode and the press
// count. Keymap entries hold nothing defined until loaded.
`timescale 1ns / 1ps
module key_scan_debounce_report_core #(
	parameter int KEYS           = ksdr_pkg::KEYS_DEF,
	parameter int KEY_SLOTS      = ksdr_pkg::KEY_SLOTS_DEF,
	parameter int STABLE_SAMPLES = ksdr_pkg::STABLE_SAMPLES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ksdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                          cfg_data,
	key_in_if.sink                        in_ch,
	report_if.source                      out_ch
);
	import ksdr_pkg::*;

	localparam int KW    = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int IW    = (KW > IDX_W) ? KW : IDX_W;
	localparam int MEM_W = HIST_W + 1;
	localparam int SUW   = $clog2(KEY_SLOTS + 1);
	localparam int SHOW  = (KEY_SLOTS < SHOWN_SLOTS) ? KEY_SLOTS : SHOWN_SLOTS;
	localparam logic [HIST_W-1:0] STABLE_MASK = HIST_W'((1 << STABLE_SAMPLES) - 1);

	// configuration registers
	logic right_q, numpad_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q  <= 1'b0;
			numpad_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RIGHT_SIDE: right_q  <= cfg_data;
				CFG_NUMPAD:     numpad_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic map_sel;
	assign map_sel = right_q & ~numpad_q;

	// input decode
	logic          accept, in_range;
	logic [IW-1:0] idx_w;
	logic [KW-1:0] in_addr;
	assign accept   = in_ch.valid & in_ch.ready;
	assign in_range = int'(in_ch.key_index) < KEYS;
	assign idx_w    = IW'(in_ch.key_index);
	assign in_addr  = idx_w[KW-1:0];

	// stage 1 pipeline registers
	logic          valid_s1;
	logic          sample_s1, range_s1, pressed_s1, last_s1, hv_s1;
	logic [KW-1:0] addr_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= accept;
	end
	always_ff @(posedge clk) begin
		sample_s1  <= (in_ch.opcode == OP_SAMPLE);
		range_s1   <= in_range;
		pressed_s1 <= in_ch.pressed;
		last_s1    <= in_ch.scan_last;
		addr_s1    <= in_addr;
	end

	// key history memory: {held, history}
	logic [MEM_W-1:0] hist_mem [2**KW];
	logic [MEM_W-1:0] hist_rd_s1, hist_wdata;
	logic             hist_we;
	always_ff @(posedge clk) begin
		hist_rd_s1 <= hist_mem[in_addr];
		if (hist_we) hist_mem[addr_s1] <= hist_wdata;
	end

	// per-key written flags stand in for a reset of the history memory
	logic [2**KW-1:0] hv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      hv_q <= '0;
		else if (hist_we) hv_q[addr_s1] <= 1'b1;
	end
	always_ff @(posedge clk) hv_s1 <= hv_q[in_addr];

	// keymap memory, loads write on acceptance
	logic [USAGE_W-1:0] key_mem [2**(KW+1)];
	logic [USAGE_W-1:0] code_s1;
	always_ff @(posedge clk) begin
		code_s1 <= key_mem[{map_sel, in_addr}];
		if (accept && in_ch.opcode == OP_LOAD && in_range)
			key_mem[{in_ch.table_select, in_addr}] <= in_ch.usage_code;
	end

	// bypass of last cycle's history write
	logic             fwd_valid_q;
	logic [KW-1:0]    fwd_addr_q;
	logic [MEM_W-1:0] fwd_data_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_valid_q <= 1'b0;
		else         fwd_valid_q <= hist_we;
	end
	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= hist_wdata;
	end

	// debounce of the sample in stage 1
	logic [MEM_W-1:0]  cur_word;
	logic [HIST_W-1:0] hist_new;
	logic              was_held, active, key_s1;
	always_comb begin
		if (fwd_valid_q && fwd_addr_q == addr_s1) cur_word = fwd_data_q;
		else if (hv_s1)                           cur_word = hist_rd_s1;
		else                                      cur_word = '0;
		key_s1     = valid_s1 & sample_s1 & range_s1;
		was_held   = cur_word[HIST_W];
		hist_new   = {cur_word[HIST_W-2:0], pressed_s1};
		active     = pressed_s1 & (was_held | ((hist_new & STABLE_MASK) == STABLE_MASK));
		hist_we    = key_s1;
		hist_wdata = {active, hist_new};
	end

	// report state
	logic [USAGE_W-1:0] mods_q, mods_n;
	logic [USAGE_W-1:0] slots_q [KEY_SLOTS];
	logic [USAGE_W-1:0] slots_n [KEY_SLOTS];
	logic [SUW-1:0]     used_q, used_n;
	logic               any_q, any_n, game_q, game_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               take, is_mod, emit;
	report_t            rpt;

	// key take and end-of-scan report
	always_comb begin
		mods_n  = mods_q;
		slots_n = slots_q;
		used_n  = used_q;
		any_n   = any_q;
		cnt_n   = cnt_q;
		take    = key_s1 & active &
			~(game_q & (code_s1 == USAGE_GUI_LEFT || code_s1 == USAGE_GUI_RIGHT));
		is_mod  = code_s1[7:3] == MOD_PREFIX;
		if (take) begin
			any_n = 1'b1;
			if (is_mod) begin
				mods_n = mods_q | (USAGE_W'(1) << code_s1[2:0]);
			end else if (int'(used_q) < KEY_SLOTS) begin
				for (int j = 0; j < KEY_SLOTS; j++) begin
					if (used_q == SUW'(j)) slots_n[j] = code_s1;
				end
				used_n = used_q + SUW'(1);
				if (code_s1 != USAGE_SPACE && !was_held) cnt_n = cnt_q + CNT_W'(1);
			end
		end
		emit = valid_s1 & sample_s1 & last_s1;
		if (!any_n) begin
			mods_n = '0;
			for (int j = 0; j < KEY_SLOTS; j++) slots_n[j] = '0;
		end
		game_n = game_q;
		if (emit && mods_n[0] && slots_n[0] == USAGE_COMMA) game_n = ~game_q;
		rpt.modifier_bits = mods_n;
		rpt.slots         = '0;
		for (int j = 0; j < SHOW; j++) rpt.slots[j] = slots_n[j];
		rpt.game_mode_on    = game_n;
		rpt.new_press_count = cnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
			for (int j = 0; j < KEY_SLOTS; j++) slots_q[j] <= '0;
			used_q <= '0;
			any_q  <= 1'b0;
			game_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			game_q <= game_n;
			cnt_q  <= cnt_n;
			if (emit) begin
				mods_q <= '0;
				for (int j = 0; j < KEY_SLOTS; j++) slots_q[j] <= '0;
				used_q <= '0;
				any_q  <= 1'b0;
			end else begin
				mods_q  <= mods_n;
				slots_q <= slots_n;
				used_q  <= used_n;
				any_q   <= any_n;
			end
		end
	end

	// two-entry output queue
	report_t    ent0_q, ent1_q;
	logic [1:0] occ_q, push_pos;
	logic       pop;
	assign pop      = (occ_q != 2'd0) & out_ch.ready;
	assign push_pos = occ_q - {1'b0, pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) occ_q <= 2'd0;
		else         occ_q <= occ_q + {1'b0, emit} - {1'b0, pop};
	end
	always_ff @(posedge clk) begin
		if (pop && occ_q == 2'd2) ent0_q <= ent1_q;
		if (emit) begin
			if (push_pos == 2'd0) ent0_q <= rpt;
			else                  ent1_q <= rpt;
		end
	end

	// room for the word in flight and a new one
	assign in_ch.ready = ({1'b0, occ_q} + {2'b0, emit}) < (3'd2 + {2'b0, pop});

	assign out_ch.valid           = occ_q != 2'd0;
	assign out_ch.modifier_bits   = ent0_q.modifier_bits;
	assign out_ch.slot_zero       = ent0_q.slots[0];
	assign out_ch.slot_one        = ent0_q.slots[1];
	assign out_ch.slot_two        = ent0_q.slots[2];
	assign out_ch.slot_three      = ent0_q.slots[3];
	assign out_ch.slot_four       = ent0_q.slots[4];
	assign out_ch.slot_five       = ent0_q.slots[5];
	assign out_ch.game_mode_on    = ent0_q.game_mode_on;
	assign out_ch.new_press_count = ent0_q.new_press_count;

endmodule
